// ===== hdl/pulse_integral_histogrammer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse integral histogrammer
// Shared property shapes used by the checker module.
// ----------------------------------------------------------------------------
`ifndef PULSE_INTEGRAL_HISTOGRAMMER_CORE_ASSERT_SVH
`define PULSE_INTEGRAL_HISTOGRAMMER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pulse integral histogrammer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PIH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pulse integral histogrammer: next-cycle check failed");

`endif

// ===== hdl/pih_pkg.sv =====
// ----------------------------------------------------------------------------
// pih_pkg
// Widths, codes and control structures shared by the histogrammer modules.
// ----------------------------------------------------------------------------
package pih_pkg;

    localparam int SAMPLE_W   = 14;
    localparam int SLOT_W     = 4;
    localparam int CAT_W      = 2;
    localparam int BIN_W      = 12;
    localparam int LEN_W      = 13;
    localparam int SEND_W     = 12;
    localparam int IDX_W      = 12;
    localparam int SUM_W      = 26;
    localparam int INT_W      = 26;
    localparam int CNT_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int PROD_W     = 39;
    localparam int NUM_W      = 41;
    localparam int DIV_W      = 40;
    localparam int DVS_W      = 13;
    localparam int BIN_WIDTH  = 100;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_READ    = 1'b1;
    localparam logic KIND_TRACE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [CAT_W-1:0] CAT_GRID    = 2'd0;
    localparam logic [CAT_W-1:0] CAT_CATHODE = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL_END     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_START = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HIGH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CATHODE_LOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CATHODE_HIGH   = 3'd6;

    localparam logic [LEN_W-1:0]  RST_TRACE_LENGTH   = 13'd2500;
    localparam logic [SEND_W-1:0] RST_SIGNAL_END     = 12'd1100;
    localparam logic [LEN_W-1:0]  RST_BASELINE_START = 13'd1500;
    localparam logic signed [INT_W-1:0] RST_WIN_LOW  = 26'sd0;
    localparam logic signed [INT_W-1:0] RST_WIN_HIGH = 26'sd200000;

    typedef struct packed {
        logic clr_wr;
        logic smp_acc;
        logic rd_acc;
        logic mul;
        logic sub;
        logic fix;
        logic eval;
        logic addr;
        logic mem_rd;
        logic mem_upd;
        logic load_trace;
        logic load_read;
    } pih_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic last;
        logic div_done;
        logic hit;
        logic out_free;
    } pih_sts_t;

endpackage

// ===== hdl/pih_div.sv =====
// ----------------------------------------------------------------------------
// pih_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pih_div import pih_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic [DVS_W-1:0]  remainder,
    output logic              done
);

    localparam int CW = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIV_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== hdl/pih_ctrl.sv =====
// ----------------------------------------------------------------------------
// pih_ctrl
// Sequencer that steps the datapath through clearing, samples and results.
// ----------------------------------------------------------------------------
module pih_ctrl import pih_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pih_sts_t sts,
    output pih_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_MUL, ST_SUB, ST_DIVI, ST_FIX, ST_EVAL,
        ST_ADDR, ST_MRD, ST_MUPD, ST_TLOAD, ST_RMEM, ST_RLOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (sts.is_read) begin
                        cmd.rd_acc = 1'b1;
                        state_next = ST_RMEM;
                    end else begin
                        cmd.smp_acc = 1'b1;
                        if (sts.last) begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB: begin
                cmd.sub    = 1'b1;
                state_next = ST_DIVI;
            end
            ST_DIVI: begin
                if (sts.div_done) begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = sts.hit ? ST_ADDR : ST_TLOAD;
            end
            ST_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = ST_MRD;
            end
            ST_MRD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MUPD;
            end
            ST_MUPD: begin
                cmd.mem_upd = 1'b1;
                state_next  = ST_TLOAD;
            end
            ST_TLOAD: begin
                if (sts.out_free) begin
                    cmd.load_trace = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_RMEM: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_RLOAD;
            end
            ST_RLOAD: begin
                if (sts.out_free) begin
                    cmd.load_read = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/pih_dp.sv =====
// ----------------------------------------------------------------------------
// pih_dp
// Accumulators, integral arithmetic, histogram memory and result register.
// ----------------------------------------------------------------------------
module pih_dp import pih_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int BINS      = 2500,
    parameter int MAX_TRACE = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_opcode,
    input  logic [SAMPLE_W-1:0]      s_sample,
    input  logic [SLOT_W-1:0]        s_slot,
    input  logic [CAT_W-1:0]         s_category,
    input  logic [BIN_W-1:0]         s_read_bin,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic                     m_kind,
    output logic signed [INT_W-1:0]  m_integral,
    output logic                     m_accepted,
    output logic [BIN_W-1:0]         m_bin,
    output logic [CNT_W-1:0]         m_count,
    input  pih_cmd_t                 cmd,
    output pih_sts_t                 sts
);

    localparam int DEPTH = SLOTS * BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [14:0] MAX_LEN = 15'(MAX_TRACE);
    localparam logic signed [NUM_W-1:0] BIN_LIMIT = NUM_W'(BINS * BIN_WIDTH);
    localparam logic signed [NUM_W-1:0] SAT_HI = NUM_W'(33554431);
    localparam logic signed [NUM_W-1:0] SAT_LO = -NUM_W'(33554432);
    // Division by the bin width as a reciprocal multiply, exact for every
    // integral below 2^19, which covers all bins up to 4096.
    localparam int             BQ_W      = 19;
    localparam int             REC_SHIFT = 26;
    localparam int             RP_W      = 39;
    localparam logic [19:0]    REC_MUL   = 20'd671089;

    // Configuration.
    logic [LEN_W-1:0]        tlen_reg;
    logic [SEND_W-1:0]       send_reg;
    logic [LEN_W-1:0]        bstart_reg;
    logic signed [INT_W-1:0] grid_lo_reg, grid_hi_reg, cath_lo_reg, cath_hi_reg;

    // Trace accumulation.
    logic [IDX_W-1:0] idx_reg;
    logic [SUM_W-1:0] sig_sum_reg, base_sum_reg;
    logic [SUM_W-1:0] sig_sum_next, base_sum_next;
    logic [SUM_W-1:0] sig_cap_reg, base_cap_reg;
    logic [LEN_W-1:0] sc_reg, bc_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [CAT_W-1:0]  cat_reg;

    // Integral arithmetic.
    logic [PROD_W-1:0]       p1_reg, p2_reg;
    logic                    neg_reg;
    logic signed [NUM_W-1:0] integ_reg;
    logic signed [NUM_W-1:0] num;
    logic [NUM_W-1:0]        q_ext, integ_fix;
    logic [DIV_W-1:0]        div_dividend, quo;
    logic [DVS_W-1:0]        div_divisor, rem;
    logic                    div_start, div_done;
    logic [RP_W-1:0]         bin_prod;
    logic [BIN_W-1:0]        bin_reg;

    // Histogram.
    logic [CNT_W-1:0] hist_mem [DEPTH];
    logic [CNT_W-1:0] mem_q_reg, cnt_inc;
    logic [AW-1:0]    addr_reg, clr_addr_reg, wr_addr;
    logic [CNT_W-1:0] wr_data;
    logic             wr_en;
    logic             rd_ok_reg;
    logic [BIN_W-1:0] rbin_reg;
    logic             res_acc_reg;
    logic [BIN_W-1:0] res_bin_reg;
    logic [CNT_W-1:0] res_cnt_reg;

    // Output register.
    logic                    m_valid_reg, m_kind_reg, m_acc_reg;
    logic signed [INT_W-1:0] m_int_reg;
    logic [BIN_W-1:0]        m_bin_reg;
    logic [CNT_W-1:0]        m_cnt_reg;

    logic [LEN_W-1:0] m_len, send_p1, sc_now, bc_now;
    logic [14:0]      eff_len, tl_ext;
    logic             in_sig, in_base, last, pass, hit, slot_ok, out_free;
    logic signed [NUM_W-1:0] win_lo, win_hi;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg    <= RST_TRACE_LENGTH;
            send_reg    <= RST_SIGNAL_END;
            bstart_reg  <= RST_BASELINE_START;
            grid_lo_reg <= RST_WIN_LOW;
            grid_hi_reg <= RST_WIN_HIGH;
            cath_lo_reg <= RST_WIN_LOW;
            cath_hi_reg <= RST_WIN_HIGH;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TRACE_LENGTH:   tlen_reg    <= cfg_data[LEN_W-1:0];
                CFG_SIGNAL_END:     send_reg    <= cfg_data[SEND_W-1:0];
                CFG_BASELINE_START: bstart_reg  <= cfg_data[LEN_W-1:0];
                CFG_GRID_LOW:       grid_lo_reg <= $signed(cfg_data);
                CFG_GRID_HIGH:      grid_hi_reg <= $signed(cfg_data);
                CFG_CATHODE_LOW:    cath_lo_reg <= $signed(cfg_data);
                CFG_CATHODE_HIGH:   cath_hi_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Sample bookkeeping for the sample offered at the input.
    always_comb begin
        m_len   = {1'b0, idx_reg} + 13'd1;
        in_sig  = idx_reg <= send_reg;
        in_base = {1'b0, idx_reg} >= bstart_reg;
        sig_sum_next  = in_sig  ? sig_sum_reg  + SUM_W'(s_sample) : sig_sum_reg;
        base_sum_next = in_base ? base_sum_reg + SUM_W'(s_sample) : base_sum_reg;
        tl_ext  = {2'b00, tlen_reg};
        if (tlen_reg == '0) begin
            eff_len = 15'd1;
        end else if (tl_ext > MAX_LEN) begin
            eff_len = MAX_LEN;
        end else begin
            eff_len = tl_ext;
        end
        last    = {2'b00, m_len} >= eff_len;
        send_p1 = {1'b0, send_reg} + 13'd1;
        sc_now  = (send_p1 < m_len) ? send_p1 : m_len;
        bc_now  = (bstart_reg < m_len) ? m_len - bstart_reg : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            sig_sum_reg  <= '0;
            base_sum_reg <= '0;
        end else if (cmd.smp_acc) begin
            if (last) begin
                idx_reg      <= '0;
                sig_sum_reg  <= '0;
                base_sum_reg <= '0;
            end else begin
                idx_reg      <= idx_reg + 1'b1;
                sig_sum_reg  <= sig_sum_next;
                base_sum_reg <= base_sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.smp_acc && last) begin
            sig_cap_reg  <= sig_sum_next;
            base_cap_reg <= base_sum_next;
            sc_reg       <= sc_now;
            bc_reg       <= bc_now;
            slot_reg     <= s_slot;
            cat_reg      <= s_category;
        end
        if (cmd.mul) begin
            p1_reg <= PROD_W'(sig_cap_reg) * PROD_W'(bc_reg);
            p2_reg <= PROD_W'(sc_reg) * PROD_W'(base_cap_reg);
        end
        if (cmd.sub) begin
            neg_reg <= (bc_reg != '0) && num[NUM_W-1];
        end
        if (cmd.fix) begin
            integ_reg <= $signed(integ_fix);
        end
        if (cmd.eval) begin
            bin_reg <= bin_prod[REC_SHIFT+BIN_W-1:REC_SHIFT];
        end
    end

    // Division operands for the baseline-mean correction.
    always_comb begin
        num = $signed({2'b00, p1_reg}) - $signed({2'b00, p2_reg});
        if (bc_reg == '0) begin
            div_dividend = DIV_W'(sig_cap_reg);
            div_divisor  = DVS_W'(1);
        end else begin
            div_dividend = num[NUM_W-1] ? DIV_W'(-num) : num[DIV_W-1:0];
            div_divisor  = bc_reg;
        end
        div_start = cmd.sub;
        q_ext     = {1'b0, quo};
        integ_fix = neg_reg ? ('0 - q_ext - NUM_W'(rem != '0)) : q_ext;
    end

    // Bin index; only used when the integral is positive and below the limit.
    assign bin_prod = RP_W'(integ_reg[BQ_W-1:0]) * RP_W'(REC_MUL);

    pih_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quo),
        .remainder (rem),
        .done      (div_done)
    );

    always_comb begin
        case (cat_reg)
            CAT_GRID: begin
                win_lo = NUM_W'(grid_lo_reg);
                win_hi = NUM_W'(grid_hi_reg);
                pass   = (integ_reg >= win_lo) && (integ_reg <= win_hi);
            end
            CAT_CATHODE: begin
                win_lo = NUM_W'(cath_lo_reg);
                win_hi = NUM_W'(cath_hi_reg);
                pass   = (integ_reg >= win_lo) && (integ_reg <= win_hi);
            end
            default: begin
                win_lo = '0;
                win_hi = '0;
                pass   = 1'b1;
            end
        endcase
        slot_ok = 32'(slot_reg) < 32'(SLOTS);
        hit     = pass && slot_ok && (integ_reg > 0) && (integ_reg < BIN_LIMIT);
    end

    // Histogram memory: the clearing sweep and the increment share one port.
    assign cnt_inc = (mem_q_reg == COUNT_MAX) ? mem_q_reg : mem_q_reg + 1'b1;
    assign wr_en   = cmd.clr_wr || cmd.mem_upd;
    assign wr_addr = cmd.clr_wr ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_wr ? '0 : cnt_inc;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cmd.mem_rd) begin
            mem_q_reg <= hist_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_acc) begin
            addr_reg  <= AW'(32'(s_slot) * 32'(BINS) + 32'(s_read_bin));
            rd_ok_reg <= (32'(s_slot) < 32'(SLOTS)) && (32'(s_read_bin) < 32'(BINS));
            rbin_reg  <= s_read_bin;
        end else if (cmd.addr) begin
            addr_reg  <= AW'(32'(slot_reg) * 32'(BINS) + 32'(bin_reg));
        end
        if (cmd.eval) begin
            res_acc_reg <= 1'b0;
            res_bin_reg <= '0;
            res_cnt_reg <= '0;
        end else if (cmd.mem_upd) begin
            res_acc_reg <= 1'b1;
            res_bin_reg <= bin_reg;
            res_cnt_reg <= cnt_inc;
        end
    end

    // Result register.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_trace || cmd.load_read) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_trace) begin
            m_kind_reg <= KIND_TRACE;
            if (integ_reg > SAT_HI) begin
                m_int_reg <= SAT_HI[INT_W-1:0];
            end else if (integ_reg < SAT_LO) begin
                m_int_reg <= SAT_LO[INT_W-1:0];
            end else begin
                m_int_reg <= integ_reg[INT_W-1:0];
            end
            m_acc_reg <= res_acc_reg;
            m_bin_reg <= res_bin_reg;
            m_cnt_reg <= res_cnt_reg;
        end else if (cmd.load_read) begin
            m_kind_reg <= KIND_READ;
            m_int_reg  <= '0;
            m_acc_reg  <= 1'b0;
            m_bin_reg  <= rbin_reg;
            m_cnt_reg  <= rd_ok_reg ? mem_q_reg : '0;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_integral = m_int_reg;
    assign m_accepted = m_acc_reg;
    assign m_bin      = m_bin_reg;
    assign m_count    = m_cnt_reg;

    assign sts.clr_last = (32'(clr_addr_reg) == 32'(DEPTH - 1));
    assign sts.is_read  = (s_opcode == OP_READ);
    assign sts.last     = last;
    assign sts.div_done = div_done;
    assign sts.hit      = hit;
    assign sts.out_free = out_free;

endmodule

// ===== hdl/pulse_integral_histogrammer_core.sv =====
// ----------------------------------------------------------------------------
// pulse_integral_histogrammer_core
// Baseline-subtracted charge integration with per-slot integral histograms.
// ----------------------------------------------------------------------------
// After reset the block first sweeps its SLOTS*BINS histogram entries to zero,
// one entry per cycle (40000 entries at the default sizes); no input
// transfer is taken during the sweep, though configuration writes are.
// A trace sample that is not the last of its trace is taken without leaving
// the idle state, so such samples can follow back to back. The last sample
// starts the integral computation: two multiplies, a restoring division
// for the baseline-mean correction, a window check with a reciprocal
// multiply by the bin width and, when the integral lands in the histogram,
// a read-modify-write of the bin. After the last sample's transfer the
// input is held off until the trace result is loaded into the output
// register; a histogram read likewise holds the input off until its
// result is loaded. The hold-off is set by the one-bit-per-cycle divider
// and the histogram read-modify-write. Results wait in an output
// register, so a stalled result port holds up the block only when the next
// result is ready to go out.
// ----------------------------------------------------------------------------
module pulse_integral_histogrammer_core import pih_pkg::*; #(
    parameter int SLOTS     = 16,
    parameter int BINS      = 2500,
    parameter int MAX_TRACE = 4096
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    // Configuration write port.
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,

    // Sample and read request channel.
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [SAMPLE_W-1:0]      s_sample,
    input  logic [SLOT_W-1:0]        s_slot,
    input  logic [CAT_W-1:0]         s_category,
    input  logic [BIN_W-1:0]         s_read_bin,

    // Result channel.
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_kind,
    output logic signed [INT_W-1:0]  m_integral,
    output logic                     m_accepted,
    output logic [BIN_W-1:0]         m_bin,
    output logic [CNT_W-1:0]         m_count
);

    pih_cmd_t cmd;
    pih_sts_t sts;

    // The controller decides which datapath operation runs in each cycle;
    // it only sees status flags and never touches payload.
    pih_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the running sums, the arithmetic,
    // the histogram memory and the output register.
    pih_dp #(
        .SLOTS     (SLOTS),
        .BINS      (BINS),
        .MAX_TRACE (MAX_TRACE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_opcode   (s_opcode),
        .s_sample   (s_sample),
        .s_slot     (s_slot),
        .s_category (s_category),
        .s_read_bin (s_read_bin),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_kind     (m_kind),
        .m_integral (m_integral),
        .m_accepted (m_accepted),
        .m_bin      (m_bin),
        .m_count    (m_count),
        .cmd        (cmd),
        .sts        (sts)
    );

endmodule

// ===== hdl/pih_checker.sv =====
// ----------------------------------------------------------------------------
// pih_checker
// Port-level checks on the result channel of the histogrammer.
// ----------------------------------------------------------------------------
`include "pulse_integral_histogrammer_core_assert.svh"

module pih_port_assertions import pih_pkg::*; (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_kind,
    input logic signed [INT_W-1:0] m_integral,
    input logic                    m_accepted,
    input logic [BIN_W-1:0]        m_bin,
    input logic [CNT_W-1:0]        m_count
);

    `PIH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_count) && $stable(m_integral) && $stable(m_bin))
    `PIH_ASSERT_IMPL(a_acc_count, aclk, aresetn, m_valid && m_kind == KIND_TRACE && m_accepted, m_count != '0 && m_integral > 0)
    `PIH_ASSERT_IMPL(a_read_fields, aclk, aresetn, m_valid && m_kind == KIND_READ, m_integral == '0 && !m_accepted)
    `PIH_ASSERT_IMPL(a_reject_zero, aclk, aresetn, m_valid && m_kind == KIND_TRACE && !m_accepted, m_bin == '0 && m_count == '0)

endmodule

bind pulse_integral_histogrammer_core pih_port_assertions u_pih_checker (.*);
